>>> rtl/sor_pkg.sv
// Shared types, constants and the rotation decode table for the sensor orientation rotate block.
`timescale 1ns / 1ps
package sor_pkg;

   localparam int IN_W  = 16;
   localparam int OUT_W = 17;
   localparam int SUM_W = 18;
   localparam int CODE_W = 6;

   // sqrt(2)/2 in Q1.15 and the rounding half for the >>> 15
   localparam logic signed [15:0] HALF_SQRT2_Q15 = 16'sd23170;
   localparam int Q15_SHIFT = 15;
   localparam logic [15:0] Q15_HALF = 16'd16384;

   typedef enum logic [CODE_W-1:0] {
      ROT_NONE                = 6'd0,
      ROT_YAW45               = 6'd1,
      ROT_YAW90               = 6'd2,
      ROT_YAW135              = 6'd3,
      ROT_YAW180              = 6'd4,
      ROT_YAW225              = 6'd5,
      ROT_YAW270              = 6'd6,
      ROT_YAW315              = 6'd7,
      ROT_ROLL180             = 6'd8,
      ROT_ROLL180_YAW45       = 6'd9,
      ROT_ROLL180_YAW90       = 6'd10,
      ROT_ROLL180_YAW135      = 6'd11,
      ROT_PITCH180            = 6'd12,
      ROT_ROLL180_YAW225      = 6'd13,
      ROT_ROLL180_YAW270      = 6'd14,
      ROT_ROLL180_YAW315      = 6'd15,
      ROT_ROLL90              = 6'd16,
      ROT_ROLL90_YAW45        = 6'd17,
      ROT_ROLL90_YAW90        = 6'd18,
      ROT_ROLL90_YAW135       = 6'd19,
      ROT_ROLL270             = 6'd20,
      ROT_ROLL270_YAW45       = 6'd21,
      ROT_ROLL270_YAW90       = 6'd22,
      ROT_ROLL270_YAW135      = 6'd23,
      ROT_PITCH90             = 6'd24,
      ROT_PITCH270            = 6'd25,
      ROT_PITCH180_YAW90      = 6'd26,
      ROT_PITCH180_YAW270     = 6'd27,
      ROT_ROLL90_PITCH90      = 6'd28,
      ROT_ROLL180_PITCH90     = 6'd29,
      ROT_ROLL270_PITCH90     = 6'd30,
      ROT_ROLL90_PITCH180     = 6'd31,
      ROT_ROLL270_PITCH180    = 6'd32,
      ROT_ROLL90_PITCH270     = 6'd33,
      ROT_ROLL180_PITCH270    = 6'd34,
      ROT_ROLL270_PITCH270    = 6'd35,
      ROT_ROLL90_PITCH180_YAW90 = 6'd36,
      ROT_ROLL90_YAW270       = 6'd37
   } rot_code_type;

   typedef enum logic [1:0] {
      AXIS_X = 2'd0,
      AXIS_Y = 2'd1,
      AXIS_Z = 2'd2
   } axis_type;

   // Sign pattern of the two scaled sums: {x_u_neg, x_v_neg, y_u_neg, y_v_neg}
   localparam logic [3:0] SGN_A = 4'b0100;  // x = k(u - v), y = k(u + v)
   localparam logic [3:0] SGN_B = 4'b1101;  // x = k(-u - v), y = k(u - v)
   localparam logic [3:0] SGN_C = 4'b1011;  // x = k(v - u), y = k(-u - v)
   localparam logic [3:0] SGN_D = 4'b0010;  // x = k(u + v), y = k(v - u)
   localparam logic [3:0] SGN_E = 4'b0001;  // x = k(u + v), y = k(u - v)
   localparam logic [3:0] SGN_F = 4'b1000;  // x = k(v - u), y = k(u + v)
   localparam logic [3:0] SGN_G = 4'b1110;  // x = k(-u - v), y = k(v - u)
   localparam logic [3:0] SGN_H = 4'b0111;  // x = k(u - v), y = k(-u - v)

   typedef struct packed {
      axis_type   x_sel;
      logic       x_neg;
      axis_type   y_sel;
      logic       y_neg;
      axis_type   z_sel;
      logic       z_neg;
      logic       scale;
      axis_type   v_sel;
      logic       v_neg;
      logic [3:0] sgn;
   } rot_ctrl_type;

   function automatic rot_ctrl_type swap_ctl(axis_type xs, logic xn, axis_type ys, logic yn,
                                             axis_type zs, logic zn);
      rot_ctrl_type c;
      c.x_sel = xs;
      c.x_neg = xn;
      c.y_sel = ys;
      c.y_neg = yn;
      c.z_sel = zs;
      c.z_neg = zn;
      c.scale = 1'b0;
      c.v_sel = AXIS_Y;
      c.v_neg = 1'b0;
      c.sgn   = 4'b0000;
      return c;
   endfunction

   // u is always the x axis; v and z come from the roll applied first
   function automatic rot_ctrl_type scale_ctl(axis_type vs, logic vn, axis_type zs, logic zn,
                                              logic [3:0] sg);
      rot_ctrl_type c;
      c.x_sel = AXIS_X;
      c.x_neg = 1'b0;
      c.y_sel = AXIS_Y;
      c.y_neg = 1'b0;
      c.z_sel = zs;
      c.z_neg = zn;
      c.scale = 1'b1;
      c.v_sel = vs;
      c.v_neg = vn;
      c.sgn   = sg;
      return c;
   endfunction

   function automatic rot_ctrl_type rot_decode(logic [CODE_W-1:0] code);
      rot_ctrl_type c;
      case (code)
         ROT_YAW45:                 c = scale_ctl(AXIS_Y, 1'b0, AXIS_Z, 1'b0, SGN_A);
         ROT_YAW90:                 c = swap_ctl(AXIS_Y, 1'b1, AXIS_X, 1'b0, AXIS_Z, 1'b0);
         ROT_YAW135:                c = scale_ctl(AXIS_Y, 1'b0, AXIS_Z, 1'b0, SGN_B);
         ROT_YAW180:                c = swap_ctl(AXIS_X, 1'b1, AXIS_Y, 1'b1, AXIS_Z, 1'b0);
         ROT_YAW225:                c = scale_ctl(AXIS_Y, 1'b0, AXIS_Z, 1'b0, SGN_C);
         ROT_YAW270:                c = swap_ctl(AXIS_Y, 1'b0, AXIS_X, 1'b1, AXIS_Z, 1'b0);
         ROT_YAW315:                c = scale_ctl(AXIS_Y, 1'b0, AXIS_Z, 1'b0, SGN_D);
         ROT_ROLL180:               c = swap_ctl(AXIS_X, 1'b0, AXIS_Y, 1'b1, AXIS_Z, 1'b1);
         ROT_ROLL180_YAW45:         c = scale_ctl(AXIS_Y, 1'b0, AXIS_Z, 1'b1, SGN_E);
         ROT_ROLL180_YAW90:         c = swap_ctl(AXIS_Y, 1'b0, AXIS_X, 1'b0, AXIS_Z, 1'b1);
         ROT_ROLL180_YAW135:        c = scale_ctl(AXIS_Y, 1'b0, AXIS_Z, 1'b1, SGN_F);
         ROT_PITCH180:              c = swap_ctl(AXIS_X, 1'b1, AXIS_Y, 1'b0, AXIS_Z, 1'b1);
         ROT_ROLL180_YAW225:        c = scale_ctl(AXIS_Y, 1'b0, AXIS_Z, 1'b1, SGN_G);
         ROT_ROLL180_YAW270:        c = swap_ctl(AXIS_Y, 1'b1, AXIS_X, 1'b1, AXIS_Z, 1'b1);
         ROT_ROLL180_YAW315:        c = scale_ctl(AXIS_Y, 1'b0, AXIS_Z, 1'b1, SGN_H);
         ROT_ROLL90:                c = swap_ctl(AXIS_X, 1'b0, AXIS_Z, 1'b1, AXIS_Y, 1'b0);
         ROT_ROLL90_YAW45:          c = scale_ctl(AXIS_Z, 1'b1, AXIS_Y, 1'b0, SGN_A);
         ROT_ROLL90_YAW90:          c = swap_ctl(AXIS_Z, 1'b0, AXIS_X, 1'b0, AXIS_Y, 1'b0);
         ROT_ROLL90_YAW135:         c = scale_ctl(AXIS_Z, 1'b1, AXIS_Y, 1'b0, SGN_B);
         ROT_ROLL270:               c = swap_ctl(AXIS_X, 1'b0, AXIS_Z, 1'b0, AXIS_Y, 1'b1);
         ROT_ROLL270_YAW45:         c = scale_ctl(AXIS_Z, 1'b0, AXIS_Y, 1'b1, SGN_A);
         ROT_ROLL270_YAW90:         c = swap_ctl(AXIS_Z, 1'b1, AXIS_X, 1'b0, AXIS_Y, 1'b1);
         ROT_ROLL270_YAW135:        c = scale_ctl(AXIS_Z, 1'b0, AXIS_Y, 1'b1, SGN_B);
         ROT_PITCH90:               c = swap_ctl(AXIS_Z, 1'b0, AXIS_Y, 1'b0, AXIS_X, 1'b1);
         ROT_PITCH270:              c = swap_ctl(AXIS_Z, 1'b1, AXIS_Y, 1'b0, AXIS_X, 1'b0);
         ROT_PITCH180_YAW90:        c = swap_ctl(AXIS_Y, 1'b1, AXIS_X, 1'b1, AXIS_Z, 1'b1);
         ROT_PITCH180_YAW270:       c = swap_ctl(AXIS_Y, 1'b0, AXIS_X, 1'b0, AXIS_Z, 1'b1);
         ROT_ROLL90_PITCH90:        c = swap_ctl(AXIS_Y, 1'b0, AXIS_Z, 1'b1, AXIS_X, 1'b1);
         ROT_ROLL180_PITCH90:       c = swap_ctl(AXIS_Z, 1'b1, AXIS_Y, 1'b1, AXIS_X, 1'b1);
         ROT_ROLL270_PITCH90:       c = swap_ctl(AXIS_Y, 1'b1, AXIS_Z, 1'b0, AXIS_X, 1'b1);
         ROT_ROLL90_PITCH180:       c = swap_ctl(AXIS_X, 1'b1, AXIS_Z, 1'b1, AXIS_Y, 1'b1);
         ROT_ROLL270_PITCH180:      c = swap_ctl(AXIS_X, 1'b1, AXIS_Z, 1'b0, AXIS_Y, 1'b0);
         ROT_ROLL90_PITCH270:       c = swap_ctl(AXIS_Y, 1'b1, AXIS_Z, 1'b1, AXIS_X, 1'b0);
         ROT_ROLL180_PITCH270:      c = swap_ctl(AXIS_Z, 1'b0, AXIS_Y, 1'b1, AXIS_X, 1'b0);
         ROT_ROLL270_PITCH270:      c = swap_ctl(AXIS_Y, 1'b0, AXIS_Z, 1'b0, AXIS_X, 1'b0);
         ROT_ROLL90_PITCH180_YAW90: c = swap_ctl(AXIS_Z, 1'b0, AXIS_X, 1'b1, AXIS_Y, 1'b1);
         ROT_ROLL90_YAW270:         c = swap_ctl(AXIS_Z, 1'b1, AXIS_X, 1'b1, AXIS_Y, 1'b0);
         default:                   c = swap_ctl(AXIS_X, 1'b0, AXIS_Y, 1'b0, AXIS_Z, 1'b0);
      endcase
      return c;
   endfunction

endpackage

>>> rtl/sor_permute.sv
// Axis swap and negation network, plus the two sums fed to the sqrt(2)/2 scalers.
`timescale 1ns / 1ps
module sor_permute
   import sor_pkg::*;
(
   input  logic signed [IN_W-1:0]  in_x,
   input  logic signed [IN_W-1:0]  in_y,
   input  logic signed [IN_W-1:0]  in_z,
   input  rot_ctrl_type            ctrl,
   output logic signed [OUT_W-1:0] perm_x,
   output logic signed [OUT_W-1:0] perm_y,
   output logic signed [OUT_W-1:0] perm_z,
   output logic signed [SUM_W-1:0] sum_x,
   output logic signed [SUM_W-1:0] sum_y
);

   logic signed [OUT_W-1:0] ax_x;
   logic signed [OUT_W-1:0] ax_y;
   logic signed [OUT_W-1:0] ax_z;
   logic signed [SUM_W-1:0] u_val;
   logic signed [SUM_W-1:0] v_val;

   function automatic logic signed [OUT_W-1:0] pick(axis_type sel, logic neg,
                                                    logic signed [OUT_W-1:0] a,
                                                    logic signed [OUT_W-1:0] b,
                                                    logic signed [OUT_W-1:0] c);
      logic signed [OUT_W-1:0] v;
      case (sel)
         AXIS_X:  v = a;
         AXIS_Y:  v = b;
         AXIS_Z:  v = c;
         default: v = a;
      endcase
      return neg ? -v : v;
   endfunction

   assign ax_x = OUT_W'(in_x);
   assign ax_y = OUT_W'(in_y);
   assign ax_z = OUT_W'(in_z);

   assign perm_x = pick(ctrl.x_sel, ctrl.x_neg, ax_x, ax_y, ax_z);
   assign perm_y = pick(ctrl.y_sel, ctrl.y_neg, ax_x, ax_y, ax_z);
   assign perm_z = pick(ctrl.z_sel, ctrl.z_neg, ax_x, ax_y, ax_z);

   // negate the terms before the sum so the scaler rounds the negated value
   assign u_val = SUM_W'(ax_x);
   assign v_val = SUM_W'(pick(ctrl.v_sel, ctrl.v_neg, ax_x, ax_y, ax_z));

   assign sum_x = (ctrl.sgn[3] ? -u_val : u_val) + (ctrl.sgn[2] ? -v_val : v_val);
   assign sum_y = (ctrl.sgn[1] ? -u_val : u_val) + (ctrl.sgn[0] ? -v_val : v_val);

endmodule

>>> rtl/sor_scale.sv
// Multiply by sqrt(2)/2 in Q1.15 with round to nearest.
`timescale 1ns / 1ps
module sor_scale
   import sor_pkg::*;
(
   input  logic signed [SUM_W-1:0] sum_in,
   output logic signed [OUT_W-1:0] scaled
);

   localparam int PROD_W = SUM_W + 16;

   logic signed [PROD_W-1:0] prod;
   logic signed [PROD_W-1:0] rounded;

   assign prod    = PROD_W'(sum_in) * PROD_W'(HALF_SQRT2_Q15);
   assign rounded = prod + PROD_W'(Q15_HALF);
   // arithmetic shift right by 15, then keep the 17 result bits
   assign scaled  = rounded[Q15_SHIFT +: OUT_W];

endmodule

>>> rtl/sensor_orientation_rotate_core.sv
// Top level: board orientation rotation of one three-axis sensor sample per cycle.
// An accepted sample is registered in the input stage, then in the result stage, and is on rsp_* for one cycle.
// One sample per cycle outside reset, set by the single pass from input to result register.
// busy is high only while reset is asserted; otherwise start is taken every cycle.
// Reset (synchronous, active high) clears the valid flags and sets orientation to none.
// The receiver cannot stall: every rsp_valid beat is consumed at the end of its cycle.
`timescale 1ns / 1ps
module sensor_orientation_rotate_core
   import sor_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   // command channel
   input  logic                    start,
   output logic                    busy,
   input  logic signed [IN_W-1:0]  req_in_x,
   input  logic signed [IN_W-1:0]  req_in_y,
   input  logic signed [IN_W-1:0]  req_in_z,
   // result channel
   output logic                    rsp_valid,
   output logic signed [OUT_W-1:0] rsp_out_x,
   output logic signed [OUT_W-1:0] rsp_out_y,
   output logic signed [OUT_W-1:0] rsp_out_z,
   // orientation register
   input  logic                    csr_wr_en,
   input  logic [CODE_W-1:0]       csr_wr_data
);

   // Orientation register
   logic [CODE_W-1:0] orient_ff;
   logic [CODE_W-1:0] orient_in;

   // Input stage: captured beat and the code it runs with
   logic                   valid_ff;
   logic                   valid_in;
   logic signed [IN_W-1:0] x_ff;
   logic signed [IN_W-1:0] y_ff;
   logic signed [IN_W-1:0] z_ff;
   logic [CODE_W-1:0]      code_ff;

   // Result stage
   logic                    rsp_valid_ff;
   logic                    rsp_valid_in;
   logic signed [OUT_W-1:0] out_x_ff;
   logic signed [OUT_W-1:0] out_y_ff;
   logic signed [OUT_W-1:0] out_z_ff;
   logic signed [OUT_W-1:0] out_x_in;
   logic signed [OUT_W-1:0] out_y_in;
   logic signed [OUT_W-1:0] out_z_in;

   // Datapath between the stages
   rot_ctrl_type            ctrl;
   logic signed [OUT_W-1:0] perm_x;
   logic signed [OUT_W-1:0] perm_y;
   logic signed [OUT_W-1:0] perm_z;
   logic signed [SUM_W-1:0] sum_x;
   logic signed [SUM_W-1:0] sum_y;
   logic signed [OUT_W-1:0] scaled_x;
   logic signed [OUT_W-1:0] scaled_y;
   logic                    accept;

   // Hold off new beats only while in reset
   assign busy   = reset;
   assign accept = start && !busy;

   assign orient_in = csr_wr_en ? csr_wr_data : orient_ff;
   assign valid_in  = accept;

   always_ff @(posedge clock) begin
      if (reset) begin
         orient_ff <= ROT_NONE;
         valid_ff  <= 1'b0;
      end else begin
         orient_ff <= orient_in;
         valid_ff  <= valid_in;
      end
   end

   // Payload of the input stage: load on every accepted beat, hold otherwise
   always_ff @(posedge clock) begin
      if (accept) begin
         x_ff    <= req_in_x;
         y_ff    <= req_in_y;
         z_ff    <= req_in_z;
         code_ff <= orient_ff;
      end
   end

   // Decode the rotation into swap/negate selects and scaled-sum signs
   assign ctrl = rot_decode(code_ff);

   sor_permute u_permute (
      .in_x   (x_ff),
      .in_y   (y_ff),
      .in_z   (z_ff),
      .ctrl   (ctrl),
      .perm_x (perm_x),
      .perm_y (perm_y),
      .perm_z (perm_z),
      .sum_x  (sum_x),
      .sum_y  (sum_y)
   );

   sor_scale u_scale_x (
      .sum_in (sum_x),
      .scaled (scaled_x)
   );

   sor_scale u_scale_y (
      .sum_in (sum_y),
      .scaled (scaled_y)
   );

   // 45-degree yaw steps take the scaled sums for x and y; z is always a plain swap
   assign out_x_in     = ctrl.scale ? scaled_x : perm_x;
   assign out_y_in     = ctrl.scale ? scaled_y : perm_y;
   assign out_z_in     = perm_z;
   assign rsp_valid_in = valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Result payload: advance with each beat leaving the input stage
   always_ff @(posedge clock) begin
      if (valid_ff) begin
         out_x_ff <= out_x_in;
         out_y_ff <= out_y_in;
         out_z_ff <= out_z_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_out_x = out_x_ff;
   assign rsp_out_y = out_y_ff;
   assign rsp_out_z = out_z_ff;

`ifndef SYNTHESIS
   // Every accepted beat comes out on rsp_valid after passing the input and result stages
   a_latency: assert property (@(posedge clock) disable iff (reset)
      accept |-> ##2 rsp_valid)
      else $error("accepted beat did not produce a result");

   // No result without an accepted beat that has passed the input and result stages
   a_no_spurious: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(accept, 2))
      else $error("result without an accepted beat");

   // With orientation none the sample passes through unchanged (x and z are checked)
   a_identity: assert property (@(posedge clock) disable iff (reset)
      (valid_ff && code_ff == ROT_NONE) |=>
         (rsp_out_x == OUT_W'($past(x_ff)) && rsp_out_z == OUT_W'($past(z_ff))))
      else $error("identity orientation altered the sample");
`endif

endmodule
